[rtl/core/tcce_pkg.sv]
// Shared constants, payload structs and command codes for the text console engine.
package tcce_pkg;

	localparam int COLUMNS  = 80;
	localparam int ROWS     = 25;
	localparam int TAB_STEP = 4;
	localparam int CELLS    = ROWS * COLUMNS;

	localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int COL_W   = $clog2(COLUMNS);
	localparam int CELL_AW = $clog2(CELLS);

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] BLANK_CHAR  = 8'h20;
	localparam logic [7:0] RESET_COLOR = 8'h07;

	// command field codes
	localparam logic [2:0] CMD_PUT_CHAR  = 3'd0;
	localparam logic [2:0] CMD_NEWLINE   = 3'd1;
	localparam logic [2:0] CMD_TAB       = 3'd2;
	localparam logic [2:0] CMD_BACKSPACE = 3'd3;
	localparam logic [2:0] CMD_CLEAR     = 3'd4;
	localparam logic [2:0] CMD_READ_CELL = 3'd5;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] char_code;
		logic [4:0] read_row;
		logic [6:0] read_column;
	} tcce_cmd_t;

	typedef struct packed {
		logic [4:0]  cursor_row_out;
		logic [6:0]  cursor_column_out;
		logic [15:0] cell_value;
	} tcce_rsp_t;

	typedef enum logic [2:0] {
		OP_PUT,
		OP_NEWLINE,
		OP_TAB,
		OP_BACKSPACE,
		OP_CLEAR,
		OP_READ,
		OP_NOP
	} tcce_op_t;

	// decoded entry carried from front to back
	typedef struct packed {
		tcce_op_t             op;
		logic [7:0]           char_code;
		logic                 read_hit;
		logic [CELL_AW-1:0]   read_addr;
	} tcce_item_t;

	typedef struct packed {
		logic booting;
	} tcce_stat_t;

endpackage

[rtl/core/tcce_front.sv]
// Front end: takes command transfers, decodes them and pushes them into the queue.
module tcce_front import tcce_pkg::*; (
	input  logic       cmd_valid,
	output logic       cmd_ready,
	input  tcce_cmd_t  cmd,
	input  logic       q_full,
	input  tcce_stat_t stat,
	output logic       q_push,
	output tcce_item_t q_item
);

	logic row_ok;
	logic col_ok;

	assign cmd_ready = !q_full && !stat.booting;
	assign q_push    = cmd_valid && cmd_ready;

	assign row_ok = 32'(cmd.read_row) < ROWS;
	assign col_ok = 32'(cmd.read_column) < COLUMNS;

	always_comb begin
		q_item.char_code = cmd.char_code;
		q_item.read_hit  = row_ok && col_ok;
		q_item.read_addr = CELL_AW'(32'(cmd.read_row) * COLUMNS + 32'(cmd.read_column));
		case (cmd.command)
			CMD_PUT_CHAR:  q_item.op = OP_PUT;
			CMD_NEWLINE:   q_item.op = OP_NEWLINE;
			CMD_TAB:       q_item.op = OP_TAB;
			CMD_BACKSPACE: q_item.op = OP_BACKSPACE;
			CMD_CLEAR:     q_item.op = OP_CLEAR;
			CMD_READ_CELL: q_item.op = OP_READ;
			default:       q_item.op = OP_NOP;
		endcase
	end

endmodule

[rtl/core/tcce_queue.sv]
// Short queue of decoded commands between front and back.
module tcce_queue import tcce_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  tcce_item_t push_item,
	output logic       full,
	output logic       valid,
	input  logic       pop,
	output tcce_item_t head
);

	tcce_item_t          ent_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign full  = count_q == (QUEUE_AW + 1)'(QUEUE_DEPTH);
	assign valid = count_q != '0;
	assign head  = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QUEUE_AW + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QUEUE_AW + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

[rtl/core/tcce_back.sv]
// Back end: cursor, row-end table, screen memory, scroll and clear sweeps, result register.
module tcce_back import tcce_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] text_color,
	input  logic       q_valid,
	input  tcce_item_t q_head,
	output logic       q_pop,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output tcce_rsp_t  rsp,
	output tcce_stat_t stat
);

	typedef enum logic [5:0] {
		ST_IDLE        = 6'b000001,
		ST_CLEAR       = 6'b000010,
		ST_SCROLL_COPY = 6'b000100,
		ST_SCROLL_ZERO = 6'b001000,
		ST_READ_WAIT   = 6'b010000,
		ST_FINISH      = 6'b100000
	} tcce_state_t;

	localparam logic [CELL_AW-1:0] LAST_CELL = CELL_AW'(CELLS - 1);
	localparam logic [CELL_AW-1:0] COPY_END  = CELL_AW'(CELLS - COLUMNS);
	localparam logic [COL_W-1:0]   LAST_COL  = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0]   LAST_ROW  = ROW_W'(ROWS - 1);

	tcce_state_t        state_q;
	logic [CELL_AW-1:0] idx_q;
	logic               pend_q;
	logic               boot_q;
	logic               is_read_q;
	logic [ROW_W-1:0]   cur_row_q;
	logic [COL_W-1:0]   cur_col_q;
	logic [COL_W-1:0]   row_end_q [ROWS];
	logic               rsp_valid_q;
	tcce_rsp_t          rsp_q;
	logic [15:0]        rd_data_q;
	logic [15:0]        mem [CELLS];

	logic               out_free;
	logic               exec;
	logic [ROW_W-1:0]   nxt_row;
	logic [COL_W-1:0]   nxt_col;
	logic               ex_wr;
	logic [ROW_W-1:0]   ex_wr_row;
	logic [COL_W-1:0]   ex_wr_col;
	logic [7:0]         ex_char;
	logic               adv_row;
	logic               scroll;
	logic               ex_clear;
	logic               ex_read;
	logic [COL_W:0]     tab_res;
	logic [COL_W-1:0]   re_upd  [ROWS];
	logic [COL_W-1:0]   re_next [ROWS];

	logic               wr_en;
	logic [CELL_AW-1:0] wr_addr;
	logic [15:0]        wr_data;
	logic               rd_en;
	logic [CELL_AW-1:0] rd_addr;
	logic               rsp_load;
	tcce_rsp_t          rsp_d;

	function automatic logic [CELL_AW-1:0] cell_addr(input logic [ROW_W-1:0] r,
		input logic [COL_W-1:0] c);
		return CELL_AW'(int'(r) * COLUMNS + int'(c));
	endfunction

	// returns {wrapped, new column}
	function automatic logic [COL_W:0] tab_step(input logic [COL_W-1:0] c);
		int   t;
		logic w;
		t = int'(c) + TAB_STEP;
		w = t >= COLUMNS;
		for (int k = 0; k < TAB_STEP / COLUMNS + 1; k++) begin
			if (t >= COLUMNS) begin
				t = t - COLUMNS;
			end
		end
		return {w, COL_W'(t)};
	endfunction

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign exec      = (state_q == ST_IDLE) && q_valid && out_free;
	assign q_pop     = exec;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign stat.booting = boot_q;
	assign tab_res   = tab_step(cur_col_q);

	// execute step of a command at the queue head
	always_comb begin
		nxt_row   = cur_row_q;
		nxt_col   = cur_col_q;
		ex_wr     = 1'b0;
		ex_wr_row = cur_row_q;
		ex_wr_col = cur_col_q;
		ex_char   = q_head.char_code;
		adv_row   = 1'b0;
		ex_clear  = 1'b0;
		ex_read   = 1'b0;
		for (int i = 0; i < ROWS; i++) begin
			re_upd[i] = row_end_q[i];
		end
		case (q_head.op)
			OP_PUT: begin
				ex_wr = 1'b1;
				re_upd[cur_row_q] = cur_col_q;
				if (cur_col_q == LAST_COL) begin
					re_upd[cur_row_q] = LAST_COL;
					nxt_col = '0;
					adv_row = 1'b1;
				end else begin
					nxt_col = cur_col_q + COL_W'(1);
				end
			end
			OP_NEWLINE: begin
				nxt_col = '0;
				adv_row = 1'b1;
			end
			OP_TAB: begin
				nxt_col = tab_res[COL_W-1:0];
				adv_row = tab_res[COL_W];
			end
			OP_BACKSPACE: begin
				if (cur_row_q != '0 || cur_col_q != '0) begin
					if (cur_col_q == '0) begin
						nxt_row = cur_row_q - ROW_W'(1);
						nxt_col = row_end_q[cur_row_q - ROW_W'(1)];
					end else begin
						nxt_col = cur_col_q - COL_W'(1);
					end
					ex_wr     = 1'b1;
					ex_wr_row = nxt_row;
					ex_wr_col = nxt_col;
					ex_char   = BLANK_CHAR;
					re_upd[nxt_row] = nxt_col;
				end
			end
			OP_CLEAR: begin
				ex_clear = 1'b1;
				nxt_row  = '0;
				nxt_col  = '0;
				for (int i = 0; i < ROWS; i++) begin
					re_upd[i] = LAST_COL;
				end
			end
			OP_READ: begin
				ex_read = q_head.read_hit;
			end
			default: begin
			end
		endcase
		scroll = adv_row && (cur_row_q == LAST_ROW);
		if (adv_row && !scroll) begin
			nxt_row = cur_row_q + ROW_W'(1);
		end
		for (int i = 0; i < ROWS; i++) begin
			if (!scroll) begin
				re_next[i] = re_upd[i];
			end else if (i == ROWS - 1) begin
				re_next[i] = LAST_COL;
			end else begin
				re_next[i] = re_upd[i + 1];
			end
		end
	end

	// memory port selection
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = '0;
		rd_en   = 1'b0;
		rd_addr = q_head.read_addr;
		case (state_q)
			ST_IDLE: begin
				wr_en   = exec && ex_wr;
				wr_addr = cell_addr(ex_wr_row, ex_wr_col);
				wr_data = {text_color, ex_char};
				rd_en   = exec && ex_read;
			end
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_data = {boot_q ? RESET_COLOR : text_color, BLANK_CHAR};
			end
			ST_SCROLL_COPY: begin
				wr_en   = pend_q;
				wr_addr = idx_q - CELL_AW'(1);
				wr_data = rd_data_q;
				rd_en   = idx_q != COPY_END;
				rd_addr = idx_q + CELL_AW'(COLUMNS);
			end
			ST_SCROLL_ZERO: begin
				wr_en   = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// result register load
	always_comb begin
		rsp_load = 1'b0;
		rsp_d.cursor_row_out    = 5'(cur_row_q);
		rsp_d.cursor_column_out = 7'(cur_col_q);
		rsp_d.cell_value        = is_read_q ? rd_data_q : '0;
		if (exec && !ex_clear && !scroll && !ex_read) begin
			rsp_load = 1'b1;
			rsp_d.cursor_row_out    = 5'(nxt_row);
			rsp_d.cursor_column_out = 7'(nxt_col);
			rsp_d.cell_value        = '0;
		end else if (state_q == ST_FINISH && out_free) begin
			rsp_load = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			idx_q       <= '0;
			pend_q      <= 1'b0;
			boot_q      <= 1'b1;
			is_read_q   <= 1'b0;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < ROWS; i++) begin
				row_end_q[i] <= LAST_COL;
			end
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (exec) begin
						cur_row_q <= nxt_row;
						cur_col_q <= nxt_col;
						is_read_q <= ex_read;
						for (int i = 0; i < ROWS; i++) begin
							row_end_q[i] <= re_next[i];
						end
						if (ex_clear) begin
							idx_q   <= '0;
							state_q <= ST_CLEAR;
						end else if (scroll) begin
							idx_q   <= '0;
							pend_q  <= 1'b0;
							state_q <= ST_SCROLL_COPY;
						end else if (ex_read) begin
							state_q <= ST_READ_WAIT;
						end
					end
				end
				ST_CLEAR: begin
					idx_q <= idx_q + CELL_AW'(1);
					if (idx_q == LAST_CELL) begin
						boot_q  <= 1'b0;
						state_q <= boot_q ? ST_IDLE : ST_FINISH;
					end
				end
				ST_SCROLL_COPY: begin
					pend_q <= 1'b1;
					if (idx_q == COPY_END) begin
						state_q <= ST_SCROLL_ZERO;
					end else begin
						idx_q <= idx_q + CELL_AW'(1);
					end
				end
				ST_SCROLL_ZERO: begin
					if (idx_q == LAST_CELL) begin
						state_q <= ST_FINISH;
					end else begin
						idx_q <= idx_q + CELL_AW'(1);
					end
				end
				ST_READ_WAIT: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						is_read_q <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule

[rtl/core/text_console_cursor_engine.sv]
// Top level of the text console engine: color register, front, queue and back.
//
// Commands come in on cmd (valid/ready); one result per command leaves on rsp
// (valid/ready) carrying the cursor after the command and, for a read, the cell.
// cfg_wr_en/cfg_wr_data write the text color byte (reset 7); write it only while
// no command is in flight.
// A put char, newline, tab, backspace or unused command that does not scroll
// goes from the queue entry register to the output register; back to back such
// commands run at one per cycle while the receiver takes results, set by the
// execute step of the back. A read in range goes on through the read-wait and
// finish states (memory read is registered). A scroll walks the screen memory,
// one cell a cycle, before its result. Clear likewise sweeps every cell.
// Reset: the cursor and row-end table clear at once, then a sweep of every cell
// fills the screen with blanks; cmd_ready stays low meanwhile.
// When the receiver stalls, the result is held in the output register; the queue
// keeps taking commands until it is full, then cmd_ready drops.
module text_console_cursor_engine import tcce_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	input  tcce_cmd_t  cmd,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output tcce_rsp_t  rsp,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data
);

	logic [7:0] text_color_q;
	logic       q_push;
	tcce_item_t q_item;
	logic       q_full;
	logic       q_valid;
	logic       q_pop;
	tcce_item_t q_head;
	tcce_stat_t stat;

	// attribute byte for written, blanked and cleared cells
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= RESET_COLOR;
		end else if (cfg_wr_en) begin
			text_color_q <= cfg_wr_data;
		end
	end

	// decode and range-check on the way into the queue
	tcce_front u_front (
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.q_full    (q_full),
		.stat      (stat),
		.q_push    (q_push),
		.q_item    (q_item)
	);

	// lets the front keep taking transfers while the back sweeps or stalls
	tcce_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.full      (q_full),
		.valid     (q_valid),
		.pop       (q_pop),
		.head      (q_head)
	);

	// cursor, screen memory and the result register
	tcce_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_color (text_color_q),
		.q_valid    (q_valid),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.stat       (stat)
	);

`ifndef SYNTH
	a_cursor_in_screen: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (32'(rsp.cursor_row_out) < ROWS) && (32'(rsp.cursor_column_out) < COLUMNS))
		else $error("cursor outside the screen");

	a_boot_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		stat.booting |-> !rsp_valid && !cmd_ready)
		else $error("transfer during reset sweep");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");
`endif

endmodule

[bench/tb_text_console_cursor_engine.sv]
// Self-checking bench for the text console engine: directed script, then paced random traffic.
module tb_text_console_cursor_engine;
	import tcce_pkg::*;

	// command codes the block does not use; they must leave everything alone
	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;

	// cycles with no transfer on either side before the run is declared hung, more
	// than a scroll or clear sweep or the long receiver hold lasts
	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;
	localparam int REPORT_MAX  = 10;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       cmd_valid   = 1'b0;
	logic       cmd_ready;
	tcce_cmd_t  cmd         = '0;
	logic       rsp_valid;
	logic       rsp_ready   = 1'b0;
	tcce_rsp_t  rsp;
	logic       cfg_wr_en   = 1'b0;
	logic [7:0] cfg_wr_data = '0;

	// pacing knobs: idle_pct is shared by the command and result sides, hold_req is for the result side
	int idle_pct  = 30;
	bit hold_req  = 1'b0;

	int mismatches   = 0;
	int results_seen = 0;

	text_console_cursor_engine u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Console shadow: screen, per-row end column, cursor and color byte.
	// ------------------------------------------------------------------
	logic [15:0]      screen_model  [CELLS];
	logic [COL_W-1:0] row_end_model [ROWS];
	int               cur_row;
	int               cur_col;
	logic [7:0]       color_model;
	tcce_rsp_t        expected_q [$];

	function automatic logic [15:0] shade(input logic [7:0] ch);
		return {color_model, ch};
	endfunction

	function automatic void wipe_screen();
		for (int i = 0; i < CELLS; i++) screen_model[i] = shade(BLANK_CHAR);
		for (int r = 0; r < ROWS; r++) row_end_model[r] = COL_W'(COLUMNS - 1);
		cur_row = 0;
		cur_col = 0;
	endfunction

	// every row moves up one; the new bottom row is all zero, not blanks
	function automatic void roll_up();
		for (int i = 0; i < CELLS - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
		for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_model[i] = '0;
		for (int r = 0; r < ROWS - 1; r++) row_end_model[r] = row_end_model[r + 1];
		row_end_model[ROWS - 1] = COL_W'(COLUMNS - 1);
	endfunction

	function automatic void line_feed();
		cur_row++;
		if (cur_row >= ROWS) begin
			roll_up();
			cur_row = ROWS - 1;
		end
	endfunction

	function automatic void stamp(input logic [7:0] ch);
		screen_model[cur_row * COLUMNS + cur_col] = shade(ch);
		row_end_model[cur_row] = COL_W'(cur_col);
	endfunction

	function automatic tcce_rsp_t console_step(input tcce_cmd_t c);
		tcce_rsp_t r;
		r = '0;
		case (c.command)
			CMD_PUT_CHAR: begin
				stamp(c.char_code);
				cur_col++;
				// wrapping off the row end marks the row as full
				if (cur_col >= COLUMNS) begin
					row_end_model[cur_row] = COL_W'(COLUMNS - 1);
					cur_col = 0;
					line_feed();
				end
			end
			CMD_NEWLINE: begin
				cur_col = 0;
				line_feed();
			end
			CMD_TAB: begin
				cur_col += TAB_STEP;
				if (cur_col >= COLUMNS) begin
					cur_col = cur_col % COLUMNS;
					line_feed();
				end
			end
			CMD_BACKSPACE: begin
				// at home nothing moves and nothing is blanked
				if (cur_row != 0 || cur_col != 0) begin
					if (cur_col == 0) begin
						cur_row--;
						cur_col = int'(row_end_model[cur_row]);
						if (cur_col >= COLUMNS) cur_col = COLUMNS - 1;
					end else begin
						cur_col--;
					end
					stamp(BLANK_CHAR);
				end
			end
			CMD_CLEAR: wipe_screen();
			CMD_READ_CELL: begin
				// out-of-range coordinates read as zero
				if (c.read_row < ROWS && c.read_column < COLUMNS)
					r.cell_value = screen_model[c.read_row * COLUMNS + c.read_column];
			end
			default: ;
		endcase
		r.cursor_row_out    = ROW_W'(cur_row);
		r.cursor_column_out = COL_W'(cur_col);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Directed script. A row with typed set carries its own expected result;
	// the rest are checked against the shadow. reps repeats the same command.
	// ------------------------------------------------------------------
	typedef struct {
		tcce_cmd_t item;
		int        reps;
		bit        typed;
		tcce_rsp_t want;
	} script_step_t;

	script_step_t script_q [$];

	function automatic void add_step(input logic [2:0] op, input logic [7:0] ch,
			input logic [4:0] rr, input logic [6:0] rc, input int reps,
			input bit typed = 1'b0, input logic [4:0] wr = '0,
			input logic [6:0] wc = '0, input logic [15:0] wcell = '0);
		script_step_t s;
		s.item.command     = op;
		s.item.char_code   = ch;
		s.item.read_row    = rr;
		s.item.read_column = rc;
		s.reps             = reps;
		s.typed            = typed;
		s.want             = {wr, wc, wcell};
		script_q.push_back(s);
	endfunction

	// mostly put-char traffic, occasional clears, reads biased to the cursor row
	function automatic tcce_cmd_t random_command();
		tcce_cmd_t c;
		int pick;
		c.char_code   = 8'($urandom_range(0, 255));
		c.read_row    = ($urandom_range(0, 99) < 85) ? 5'($urandom_range(0, ROWS - 1))
		                                              : 5'($urandom_range(ROWS, 31));
		c.read_column = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(0, COLUMNS - 1))
		                                              : 7'($urandom_range(COLUMNS, 127));
		pick = $urandom_range(0, 999);
		if (pick < 460)      c.command = CMD_PUT_CHAR;
		else if (pick < 540) c.command = CMD_NEWLINE;
		else if (pick < 640) c.command = CMD_TAB;
		else if (pick < 770) c.command = CMD_BACKSPACE;
		else if (pick < 775) c.command = CMD_CLEAR;
		else if (pick < 975) c.command = CMD_READ_CELL;
		else                 c.command = $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
		// a good share of reads look at the row just written
		if (c.command == CMD_READ_CELL && $urandom_range(0, 99) < 35)
			c.read_row = ROW_W'(cur_row);
		return c;
	endfunction

	// ------------------------------------------------------------------
	// Command side: optional gap, then hold valid until the transfer.
	// ------------------------------------------------------------------
	task automatic issue(input tcce_cmd_t c, input bit typed, input tcce_rsp_t want);
		tcce_rsp_t predicted;
		int gap;
		gap = 0;
		if ($urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 16);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		predicted = console_step(c);
		expected_q.push_back(typed ? want : predicted);
	endtask

	// drop valid and wait until every outstanding result has been taken
	task automatic drain();
		cmd_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_color(input logic [7:0] value);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		color_model = value;
	endtask

	// each phase opens with a clear so the new color shows up in blanks
	task automatic run_random(input int count, input int pct);
		tcce_cmd_t c;
		idle_pct  = pct;
		c         = '0;
		c.command = CMD_CLEAR;
		issue(c, 1'b0, '0);
		repeat (count) issue(random_command(), 1'b0, '0);
	endtask

	// ------------------------------------------------------------------
	// Result side pacing: ready bursts, plus one long hold-off so the
	// command queue fills and cmd_ready drops while the sender keeps going.
	// ------------------------------------------------------------------
	initial begin : rsp_pacing
		int span;
		bit held_off;
		held_off = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req && !held_off) begin
				held_off = 1'b1;
				rsp_ready <= 1'b0;
				span = HOLD_CYCLES;
			end else if ($urandom_range(0, 99) < idle_pct) begin
				rsp_ready <= 1'b0;
				span = $urandom_range(1, 16);
			end else begin
				rsp_ready <= 1'b1;
				span = $urandom_range(1, 16);
			end
			repeat (span) @(posedge clk);
		end
	end

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin : rsp_check
		tcce_rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_q.size() == 0) begin
				if (mismatches < REPORT_MAX)
					$display("result %0d with nothing pending: row %0d col %0d cell %h",
						results_seen, rsp.cursor_row_out, rsp.cursor_column_out,
						rsp.cell_value);
				mismatches++;
			end else begin
				want = expected_q.pop_front();
				if (rsp.cursor_row_out !== want.cursor_row_out ||
						rsp.cursor_column_out !== want.cursor_column_out ||
						rsp.cell_value !== want.cell_value) begin
					if (mismatches < REPORT_MAX)
						$display("result %0d: expected row %0d col %0d cell %h,",
							results_seen, want.cursor_row_out,
							want.cursor_column_out, want.cell_value,
							" got row %0d col %0d cell %h",
							rsp.cursor_row_out, rsp.cursor_column_out,
							rsp.cell_value);
					mismatches++;
				end
			end
			results_seen++;
		end
	end

	// hang detector: no transfer on either side for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) quiet = 0;
			else quiet++;
		end
		$display("[text_console_cursor_engine] ERROR");
		$finish;
	end

	initial begin : stimulus
		color_model = RESET_COLOR;
		wipe_screen();

		// reset contents in the reset color, and read range edges
		add_step(CMD_READ_CELL, 8'h00, 5'd0, 7'd0, 1, 1'b1, 5'd0, 7'd0, 16'h0720);
		add_step(CMD_READ_CELL, 8'h00, 5'd24, 7'd79, 1, 1'b1, 5'd0, 7'd0, 16'h0720);
		add_step(CMD_READ_CELL, 8'h00, 5'd25, 7'd0, 1, 1'b1, 5'd0, 7'd0, 16'h0000);
		add_step(CMD_READ_CELL, 8'h00, 5'd0, 7'd80, 1, 1'b1, 5'd0, 7'd0, 16'h0000);
		add_step(CMD_READ_CELL, 8'hFF, 5'd31, 7'd127, 1, 1'b1, 5'd0, 7'd0, 16'h0000);
		// backspace at home is a no-op
		add_step(CMD_BACKSPACE, 8'h00, 5'd0, 7'd0, 1, 1'b1, 5'd0, 7'd0, 16'h0000);
		add_step(CMD_PUT_CHAR, 8'hFF, 5'd31, 7'd127, 1, 1'b1, 5'd0, 7'd1, 16'h0000);
		add_step(CMD_PUT_CHAR, 8'h00, 5'd0, 7'd0, 1, 1'b1, 5'd0, 7'd2, 16'h0000);
		add_step(CMD_TAB, 8'h00, 5'd0, 7'd0, 1, 1'b1, 5'd0, 7'd6, 16'h0000);
		add_step(CMD_BACKSPACE, 8'h00, 5'd0, 7'd0, 1, 1'b1, 5'd0, 7'd5, 16'h0000);
		add_step(CMD_READ_CELL, 8'h00, 5'd0, 7'd0, 1, 1'b1, 5'd0, 7'd5, 16'h07FF);
		add_step(CMD_NEWLINE, 8'h00, 5'd0, 7'd0, 1, 1'b1, 5'd1, 7'd0, 16'h0000);
		// from column zero backspace lands on the remembered end of the row above
		add_step(CMD_BACKSPACE, 8'h00, 5'd0, 7'd0, 1);
		add_step(CMD_SPARE_6, 8'hFF, 5'd3, 7'd3, 1, 1'b1, 5'd0, 7'd5, 16'h0000);
		add_step(CMD_SPARE_7, 8'hFF, 5'd0, 7'd0, 1, 1'b1, 5'd0, 7'd5, 16'h0000);
		add_step(CMD_CLEAR, 8'h00, 5'd0, 7'd0, 1, 1'b1, 5'd0, 7'd0, 16'h0000);
		add_step(CMD_PUT_CHAR, 8'h41, 5'd0, 7'd0, 1, 1'b1, 5'd0, 7'd1, 16'h0000);
		// walk to the bottom row, then scroll by newline
		add_step(CMD_NEWLINE, 8'h00, 5'd0, 7'd0, 24);
		add_step(CMD_PUT_CHAR, 8'h42, 5'd0, 7'd0, 1);
		add_step(CMD_NEWLINE, 8'h00, 5'd0, 7'd0, 1);
		add_step(CMD_READ_CELL, 8'h00, 5'd23, 7'd0, 1);
		add_step(CMD_READ_CELL, 8'h00, 5'd24, 7'd5, 1);
		add_step(CMD_READ_CELL, 8'h00, 5'd0, 7'd0, 1);
		// row-end table must have moved up with the rows
		add_step(CMD_BACKSPACE, 8'h00, 5'd0, 7'd0, 1);
		add_step(CMD_NEWLINE, 8'h00, 5'd0, 7'd0, 1);
		// scroll by tab wrap, then by put-char wrap on the last row
		add_step(CMD_TAB, 8'h00, 5'd0, 7'd0, 20);
		add_step(CMD_TAB, 8'h00, 5'd0, 7'd0, 19);
		add_step(CMD_PUT_CHAR, 8'h55, 5'd0, 7'd0, 4);
		add_step(CMD_READ_CELL, 8'h00, 5'd23, 7'd79, 1);
		add_step(CMD_BACKSPACE, 8'h00, 5'd0, 7'd0, 1);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		idle_pct = 30;
		foreach (script_q[i])
			repeat (script_q[i].reps) issue(script_q[i].item, script_q[i].typed, script_q[i].want);

		// color extremes, a random color, then a final stretch with no idling
		write_color(8'h00);
		run_random(300, 30);
		write_color(8'hFF);
		hold_req = 1'b1;
		run_random(300, 10);
		write_color(8'($urandom_range(1, 254)));
		run_random(300, 50);
		write_color(8'h5A);
		run_random(300, 0);

		cmd_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("[text_console_cursor_engine] OK");
		else
			$display("[text_console_cursor_engine] ERROR");
		$finish;
	end

endmodule
